// File: hdl/dma4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma4 package
// shared constants, command codes and queue entry type for the dma block
// ----------------------------------------------------------------------------
package dma4_pkg;

	localparam int NumCh       = 4;
	localparam int StartDelayD = 2;

	localparam logic [2:0] CMD_WRITE   = 3'd0;
	localparam logic [2:0] CMD_READ    = 3'd1;
	localparam logic [2:0] CMD_HBLANK  = 3'd2;
	localparam logic [2:0] CMD_VBLANK  = 3'd3;
	localparam logic [2:0] CMD_CAP_ON  = 3'd4;
	localparam logic [2:0] CMD_CAP_OFF = 3'd5;
	localparam logic [2:0] CMD_TIMER   = 3'd6;
	localparam logic [2:0] CMD_TICK    = 3'd7;

	localparam logic [1:0] STEP_INC    = 2'd0;
	localparam logic [1:0] STEP_DEC    = 2'd1;
	localparam logic [1:0] STEP_FIXED  = 2'd2;
	localparam logic [1:0] STEP_RELOAD = 2'd3;

	localparam logic [1:0] TIME_NOW     = 2'd0;
	localparam logic [1:0] TIME_VBLANK  = 2'd1;
	localparam logic [1:0] TIME_HBLANK  = 2'd2;
	localparam logic [1:0] TIME_SPECIAL = 2'd3;

	localparam logic [31:0] FIFO_A_ADDR = 32'h040000A0;
	localparam logic [31:0] FIFO_B_ADDR = 32'h040000A4;
	localparam logic [31:0] CART_BASE   = 32'h08000000;

	// decoded item handed from front to back
	typedef struct packed {
		logic [2:0] command;
		logic       in_range;
		logic [1:0] ch;
		logic [3:0] idx;
		logic [7:0] write_byte;
		logic       fifo_select;
	} item_t;

endpackage

// File: hdl/dma4_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma4 front
// accepts items, splits the register offset into channel and byte index
// ----------------------------------------------------------------------------
module dma4_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       command,
	input  logic [5:0]       reg_offset,
	input  logic [7:0]       write_byte,
	input  logic             fifo_select,
	output logic             q_valid,
	input  logic             q_ready,
	output dma4_pkg::item_t  q_item
);
	logic            full_q;
	dma4_pkg::item_t item_q;
	dma4_pkg::item_t dec;
	logic [5:0]      rem;

	always_comb begin
		dec = '0;
		dec.command     = command;
		dec.write_byte  = write_byte;
		dec.fifo_select = fifo_select;
		dec.in_range    = (reg_offset < 6'd48);
		if (reg_offset < 6'd12) begin
			dec.ch = 2'd0; rem = reg_offset;
		end else if (reg_offset < 6'd24) begin
			dec.ch = 2'd1; rem = reg_offset - 6'd12;
		end else if (reg_offset < 6'd36) begin
			dec.ch = 2'd2; rem = reg_offset - 6'd24;
		end else begin
			dec.ch = 2'd3; rem = reg_offset - 6'd36;
		end
		dec.idx = rem[3:0];
	end

	assign in_ready = !full_q || q_ready;
	assign q_valid  = full_q;
	assign q_item   = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ready) begin
			full_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= dec;
		end
	end
endmodule

// File: hdl/dma4_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma4 back
// channel registers, start countdowns, tick sequencing and the result register
// ----------------------------------------------------------------------------
module dma4_back #(
	parameter int START_DELAY = dma4_pkg::StartDelayD
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  dma4_pkg::item_t q_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      read_byte,
	output logic            xfer_valid,
	output logic [1:0]      xfer_channel,
	output logic [31:0]     xfer_source,
	output logic [31:0]     xfer_dest,
	output logic            xfer_word,
	output logic            xfer_done,
	output logic            irq_request,
	output logic            busy_res
);
	localparam logic [3:0] DELAY = 4'(START_DELAY);

	logic [27:0] src_reg_q  [4];
	logic [27:0] dst_reg_q  [4];
	logic [15:0] cnt_reg_q  [4];
	logic [15:0] ctl_q      [4];
	logic [31:0] src_now_q  [4];
	logic [31:0] dst_now_q  [4];
	logic [16:0] cnt_now_q  [4];
	logic [3:0]  active_q;
	logic [3:0]  cd_q       [4];

	logic [27:0] src_reg_d  [4];
	logic [27:0] dst_reg_d  [4];
	logic [15:0] cnt_reg_d  [4];
	logic [15:0] ctl_d      [4];
	logic [31:0] src_now_d  [4];
	logic [31:0] dst_now_d  [4];
	logic [16:0] cnt_now_d  [4];
	logic [3:0]  active_d;
	logic [3:0]  cd_d       [4];

	logic        out_full_q;
	logic [7:0]  rb_d;
	logic        xv_d, xw_d, xdone_d, irq_d;
	logic [1:0]  xch_d;
	logic [31:0] xs_d, xd_d;
	logic        fire;

	assign q_ready = !out_full_q || out_ready;
	assign fire    = q_valid && q_ready;
	assign out_valid = out_full_q;

	function automatic logic [16:0] load_len(input logic [1:0] c, input logic [15:0] r);
		logic [16:0] m;
		m = (c == 2'd3) ? {1'b0, r} : {3'b0, r[13:0]};
		if (m == 17'd0) m = (c == 2'd3) ? 17'h10000 : 17'h04000;
		return m;
	endfunction

	function automatic logic [31:0] step(input logic [31:0] a, input logic [1:0] k,
		input logic [31:0] amt);
		case (k)
			dma4_pkg::STEP_DEC:   return a - amt;
			dma4_pkg::STEP_FIXED: return a;
			default:              return a + amt;
		endcase
	endfunction

	always_comb begin
		logic [1:0]  c;
		logic [3:0]  ix;
		logic [7:0]  v;
		logic        old_en, found, audio, word;
		logic [1:0]  cur, sk, dk;
		logic [15:0] ctl;
		logic [31:0] amt, fa;
		for (int i = 0; i < 4; i++) begin
			src_reg_d[i] = src_reg_q[i]; dst_reg_d[i] = dst_reg_q[i];
			cnt_reg_d[i] = cnt_reg_q[i]; ctl_d[i] = ctl_q[i];
			src_now_d[i] = src_now_q[i]; dst_now_d[i] = dst_now_q[i];
			cnt_now_d[i] = cnt_now_q[i]; cd_d[i] = cd_q[i];
		end
		active_d = active_q;
		rb_d = '0; xv_d = 1'b0; xw_d = 1'b0; xdone_d = 1'b0; irq_d = 1'b0;
		xch_d = '0; xs_d = '0; xd_d = '0;
		c = q_item.ch; ix = q_item.idx; v = q_item.write_byte;
		found = 1'b0; cur = '0; audio = 1'b0; word = 1'b0; ctl = '0; amt = '0;
		sk = '0; dk = '0;
		fa = q_item.fifo_select ? dma4_pkg::FIFO_B_ADDR : dma4_pkg::FIFO_A_ADDR;
		old_en = ctl_q[c][15];
		case (q_item.command)
			dma4_pkg::CMD_WRITE: begin
				if (q_item.in_range) begin
					case (ix)
						4'd0: src_reg_d[c][7:0]   = v;
						4'd1: src_reg_d[c][15:8]  = v;
						4'd2: src_reg_d[c][23:16] = v;
						4'd3: src_reg_d[c][27:24] = (c == 2'd0) ? {1'b0, v[2:0]} : v[3:0];
						4'd4: dst_reg_d[c][7:0]   = v;
						4'd5: dst_reg_d[c][15:8]  = v;
						4'd6: dst_reg_d[c][23:16] = v;
						4'd7: dst_reg_d[c][27:24] = (c == 2'd3) ? v[3:0] : {1'b0, v[2:0]};
						4'd8: cnt_reg_d[c][7:0]   = v;
						4'd9: cnt_reg_d[c][15:8]  = v;
						4'd10: ctl_d[c][7:0] = v & 8'hE0;
						default: ctl_d[c][15:8] = v & ((c == 2'd3) ? 8'hFF : 8'hF7);
					endcase
					if (ctl_d[c][15] && !old_en) begin
						src_now_d[c] = {4'b0, src_reg_d[c]} &
							~(ctl_d[c][10] ? 32'd3 : 32'd1);
						dst_now_d[c] = {4'b0, dst_reg_d[c]} &
							~(ctl_d[c][10] ? 32'd3 : 32'd1);
						cnt_now_d[c] = load_len(c, cnt_reg_d[c]);
						if (ctl_d[c][13:12] == dma4_pkg::TIME_NOW) cd_d[c] = DELAY;
					end
				end
			end
			dma4_pkg::CMD_READ: begin
				if (q_item.in_range && ix == 4'd10) rb_d = ctl_q[c][7:0];
				else if (q_item.in_range && ix == 4'd11) rb_d = ctl_q[c][15:8];
			end
			dma4_pkg::CMD_HBLANK, dma4_pkg::CMD_VBLANK: begin
				for (int i = 0; i < 4; i++) begin
					if (!active_q[i] && ctl_q[i][15] && ctl_q[i][13:12] ==
						((q_item.command == dma4_pkg::CMD_HBLANK) ?
						dma4_pkg::TIME_HBLANK : dma4_pkg::TIME_VBLANK))
						cd_d[i] = DELAY;
				end
			end
			dma4_pkg::CMD_CAP_ON: begin
				if (!active_q[3] && ctl_q[3][15] && ctl_q[3][13:12] == dma4_pkg::TIME_SPECIAL)
					cd_d[3] = DELAY;
			end
			dma4_pkg::CMD_CAP_OFF: begin
				if (ctl_q[3][15] && ctl_q[3][13:12] == dma4_pkg::TIME_SPECIAL)
					ctl_d[3][15] = 1'b0;
			end
			dma4_pkg::CMD_TIMER: begin
				for (int i = 1; i <= 2; i++) begin
					if (ctl_q[i][13:12] == dma4_pkg::TIME_SPECIAL &&
						{4'b0, dst_reg_q[i]} == fa && ctl_q[i][9]) begin
						ctl_d[i][15] = 1'b1;
						cnt_now_d[i] = 17'd4;
						cd_d[i] = DELAY;
					end
				end
			end
			default: begin
				// lowest active channel wins the tick
				for (int i = 3; i >= 0; i--) begin
					if (active_q[i]) begin
						found = 1'b1; cur = 2'(i);
					end
				end
				if (found) begin
					ctl   = ctl_q[cur];
					audio = (cur == 2'd1 || cur == 2'd2) &&
						ctl[13:12] == dma4_pkg::TIME_SPECIAL;
					word  = ctl[10] || audio;
					amt   = word ? 32'd4 : 32'd2;
					if (src_now_q[cur] >= dma4_pkg::CART_BASE) ctl[8:7] = 2'b00;
					sk = ctl[8:7];
					dk = audio ? dma4_pkg::STEP_FIXED : ctl[6:5];
					xv_d = 1'b1; xch_d = cur; xs_d = src_now_q[cur];
					xd_d = dst_now_q[cur]; xw_d = word;
					src_now_d[cur] = step(src_now_q[cur], sk, amt);
					dst_now_d[cur] = step(dst_now_q[cur], dk, amt);
					cnt_now_d[cur] = cnt_now_q[cur] - 17'd1;
					if (cnt_now_d[cur] == 17'd0) begin
						xdone_d = 1'b1;
						active_d[cur] = 1'b0;
						if (ctl[9]) begin
							if (ctl[6:5] == dma4_pkg::STEP_RELOAD)
								dst_now_d[cur] = {4'b0, dst_reg_q[cur]} &
									~(word ? 32'd3 : 32'd1);
							cnt_now_d[cur] = load_len(cur, cnt_reg_q[cur]);
						end else begin
							ctl_d[cur][15] = 1'b0;
						end
						irq_d = ctl[14];
					end
				end
				for (int i = 0; i < 4; i++) begin
					if (cd_q[i] != 4'd0) begin
						cd_d[i] = cd_q[i] - 4'd1;
						if (cd_d[i] == 4'd0) active_d[i] = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				src_reg_q[i] <= '0; dst_reg_q[i] <= '0; cnt_reg_q[i] <= '0;
				ctl_q[i] <= '0; src_now_q[i] <= '0; dst_now_q[i] <= '0;
				cnt_now_q[i] <= '0; cd_q[i] <= '0;
			end
			active_q   <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (fire) begin
				for (int i = 0; i < 4; i++) begin
					src_reg_q[i] <= src_reg_d[i]; dst_reg_q[i] <= dst_reg_d[i];
					cnt_reg_q[i] <= cnt_reg_d[i]; ctl_q[i] <= ctl_d[i];
					src_now_q[i] <= src_now_d[i]; dst_now_q[i] <= dst_now_d[i];
					cnt_now_q[i] <= cnt_now_d[i]; cd_q[i] <= cd_d[i];
				end
				active_q <= active_d;
			end
			if (q_ready) out_full_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_byte    <= rb_d;
			xfer_valid   <= xv_d;
			xfer_channel <= xch_d;
			xfer_source  <= xs_d;
			xfer_dest    <= xd_d;
			xfer_word    <= xw_d;
			xfer_done    <= xdone_d;
			irq_request  <= irq_d;
			busy_res     <= |active_d;
		end
	end
endmodule

// File: hdl/four_channel_dma_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four channel dma controller
// address sequencing for four dma channels; bus data moves elsewhere
// ----------------------------------------------------------------------------
// usage:
//  - input channel (in_valid/in_ready) carries one item: a register byte
//    write or read, a start event (hblank, vblank, capture, timer) or a tick
//  - output channel (out_valid/out_ready) returns exactly one result per item
//  - on a tick the lowest active channel reports a transfer unit (addresses,
//    size, done, irq) and then steps; start countdowns step after that
//  - each item passes the front register, then the channel state update which
//    also loads the result register
//  - throughput is one item per cycle, set by the state update, unless the receiver stalls
//  - the front register is a one-entry queue; a stalled receiver backs up
//    into it and only then drops in_ready, with no item lost
//  - reset clears all channel registers, counters and countdowns
// ----------------------------------------------------------------------------
module four_channel_dma_controller_unit #(
	parameter int START_DELAY = dma4_pkg::StartDelayD
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [5:0]  reg_offset,
	input  logic [7:0]  write_byte,
	input  logic        fifo_select,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_byte,
	output logic        xfer_valid,
	output logic [1:0]  xfer_channel,
	output logic [31:0] xfer_source,
	output logic [31:0] xfer_dest,
	output logic        xfer_word,
	output logic        xfer_done,
	output logic        irq_request,
	output logic        busy_res
);
	// queue between front and back
	logic            q_valid;
	logic            q_ready;
	dma4_pkg::item_t q_item;

	dma4_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .reg_offset(reg_offset),
		.write_byte(write_byte), .fifo_select(fifo_select),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	dma4_back #(.START_DELAY(START_DELAY)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_byte(read_byte), .xfer_valid(xfer_valid),
		.xfer_channel(xfer_channel), .xfer_source(xfer_source),
		.xfer_dest(xfer_dest), .xfer_word(xfer_word),
		.xfer_done(xfer_done), .irq_request(irq_request),
		.busy_res(busy_res)
	);
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four channel dma controller testbench
// drives register writes, reads, start events and ticks through a valid/ready
// channel and checks every result against a cycle-free model of the channels
// ----------------------------------------------------------------------------
module testbench;

	// one result as seen on the output port
	typedef struct packed {
		logic [7:0]  rd;
		logic        xv;
		logic [1:0]  xch;
		logic [31:0] xs;
		logic [31:0] xd;
		logic        xw;
		logic        xdone;
		logic        irq;
		logic        busy;
	} dma_result_t;

	// one directed row: item plus an optional typed-in result
	typedef struct {
		logic [2:0]  cmd;
		logic [5:0]  off;
		logic [7:0]  wb;
		logic        fs;
		bit          fixed;
		dma_result_t res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  command;
	logic [5:0]  reg_offset;
	logic [7:0]  write_byte;
	logic        fifo_select;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  read_byte;
	logic        xfer_valid;
	logic [1:0]  xfer_channel;
	logic [31:0] xfer_source;
	logic [31:0] xfer_dest;
	logic        xfer_word;
	logic        xfer_done;
	logic        irq_request;
	logic        busy_res;

	four_channel_dma_controller_unit u_dut (.*);

	// predictor copy of the channel state
	logic [27:0] m_src[4];
	logic [27:0] m_dst[4];
	logic [15:0] m_len[4];
	logic [15:0] m_ctl[4];
	logic [31:0] m_src_now[4];
	logic [31:0] m_dst_now[4];
	logic [16:0] m_cnt[4];
	logic        m_act[4];
	logic [3:0]  m_cd[4];

	dma_result_t expected_results[$];
	int          fail_count;
	int          hold_off;      // long receiver stall request, in cycles

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#50ms;
		$display("status: fail");
		$finish;
	end

	function automatic logic [31:0] len_reload(int c);
		logic [15:0] m;
		m = (c == 3) ? m_len[c] : (m_len[c] & 16'h3FFF);
		if (m == 0)
			return (c == 3) ? 32'h10000 : 32'h4000;
		return {16'd0, m};
	endfunction

	function automatic logic [31:0] step_address(logic [31:0] a, logic [1:0] k, logic [31:0] amt);
		if (k == dma4_pkg::STEP_DEC)
			return a - amt;
		if (k == dma4_pkg::STEP_FIXED)
			return a;
		return a + amt;
	endfunction

	// apply one item to the channel copy and return its result
	function automatic dma_result_t dma_predict(logic [2:0] cmd, logic [5:0] off,
			logic [7:0] wb, logic fs);
		dma_result_t r;
		int c, x, cur;
		logic [3:0] ix;
		logic old_en, aud, wd;
		logic [15:0] ctl;
		logic [31:0] amt, al, fa;
		logic [1:0] sk, dk;
		r = '0;
		c = off / 12;
		ix = off % 12;
		case (cmd)
		dma4_pkg::CMD_WRITE: if (off < 48) begin
			old_en = m_ctl[c][15];
			if (ix < 4) begin
				if (ix == 3)
					m_src[c][27:24] = (c == 0) ? {1'b0, wb[2:0]} : wb[3:0];
				else
					m_src[c][ix*8 +: 8] = wb;
			end else if (ix < 8) begin
				if (ix == 7)
					m_dst[c][27:24] = (c == 3) ? wb[3:0] : {1'b0, wb[2:0]};
				else
					m_dst[c][(ix-4)*8 +: 8] = wb;
			end else if (ix < 10)
				m_len[c][(ix-8)*8 +: 8] = wb;
			else if (ix == 10)
				m_ctl[c][7:0] = wb & 8'hE0;
			else
				m_ctl[c][15:8] = wb & ((c == 3) ? 8'hFF : 8'hF7);
			if (m_ctl[c][15] && !old_en) begin
				al = m_ctl[c][10] ? 32'd3 : 32'd1;
				m_src_now[c] = {4'd0, m_src[c]} & ~al;
				m_dst_now[c] = {4'd0, m_dst[c]} & ~al;
				m_cnt[c] = len_reload(c);
				if (m_ctl[c][13:12] == dma4_pkg::TIME_NOW)
					m_cd[c] = dma4_pkg::StartDelayD;
			end
		end
		dma4_pkg::CMD_READ: if (off < 48) begin
			if (ix == 10)
				r.rd = m_ctl[c][7:0];
			else if (ix == 11)
				r.rd = m_ctl[c][15:8];
		end
		dma4_pkg::CMD_HBLANK, dma4_pkg::CMD_VBLANK:
			for (x = 0; x < 4; x++)
				if (!m_act[x] && m_ctl[x][15] &&
						m_ctl[x][13:12] == ((cmd == dma4_pkg::CMD_HBLANK) ?
						dma4_pkg::TIME_HBLANK : dma4_pkg::TIME_VBLANK))
					m_cd[x] = dma4_pkg::StartDelayD;
		dma4_pkg::CMD_CAP_ON:
			if (!m_act[3] && m_ctl[3][15] && m_ctl[3][13:12] == dma4_pkg::TIME_SPECIAL)
				m_cd[3] = dma4_pkg::StartDelayD;
		dma4_pkg::CMD_CAP_OFF:
			if (m_ctl[3][15] && m_ctl[3][13:12] == dma4_pkg::TIME_SPECIAL)
				m_ctl[3][15] = 1'b0;
		dma4_pkg::CMD_TIMER: begin
			fa = fs ? dma4_pkg::FIFO_B_ADDR : dma4_pkg::FIFO_A_ADDR;
			for (x = 1; x <= 2; x++)
				if (m_ctl[x][13:12] == dma4_pkg::TIME_SPECIAL &&
						{4'd0, m_dst[x]} == fa && m_ctl[x][9]) begin
					m_ctl[x][15] = 1'b1;
					m_cnt[x] = 17'd4;
					m_cd[x] = dma4_pkg::StartDelayD;
				end
		end
		default: begin
			// lowest active channel moves one unit, then countdowns step
			cur = -1;
			for (x = 3; x >= 0; x--)
				if (m_act[x])
					cur = x;
			if (cur >= 0) begin
				ctl = m_ctl[cur];
				aud = (cur == 1 || cur == 2) && ctl[13:12] == dma4_pkg::TIME_SPECIAL;
				wd = ctl[10] || aud;
				amt = wd ? 32'd4 : 32'd2;
				if (m_src_now[cur] >= dma4_pkg::CART_BASE)
					ctl[8:7] = dma4_pkg::STEP_INC;
				sk = ctl[8:7];
				dk = aud ? dma4_pkg::STEP_FIXED : ctl[6:5];
				r.xv = 1'b1;
				r.xch = cur;
				r.xs = m_src_now[cur];
				r.xd = m_dst_now[cur];
				r.xw = wd;
				m_src_now[cur] = step_address(m_src_now[cur], sk, amt);
				m_dst_now[cur] = step_address(m_dst_now[cur], dk, amt);
				m_cnt[cur] = m_cnt[cur] - 1'b1;
				if (m_cnt[cur] == 0) begin
					r.xdone = 1'b1;
					m_act[cur] = 1'b0;
					if (ctl[9]) begin
						if (ctl[6:5] == dma4_pkg::STEP_RELOAD)
							m_dst_now[cur] = {4'd0, m_dst[cur]} & ~(wd ? 32'd3 : 32'd1);
						m_cnt[cur] = len_reload(cur);
					end else
						m_ctl[cur][15] = 1'b0;
					r.irq = ctl[14];
				end
			end
			for (x = 0; x < 4; x++)
				if (m_cd[x] != 0) begin
					m_cd[x] = m_cd[x] - 1'b1;
					if (m_cd[x] == 0)
						m_act[x] = 1'b1;
				end
		end
		endcase
		for (x = 0; x < 4; x++)
			r.busy = r.busy | m_act[x];
		return r;
	endfunction

	// send one item; the predictor runs at acceptance
	// valid drops only when an idle gap follows, so back to back items keep it high
	task automatic send_item(logic [2:0] cmd, logic [5:0] off, logic [7:0] wb, logic fs,
			bit fixed = 0, dma_result_t res = '0);
		int gap;
		dma_result_t p;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 7) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		reg_offset <= off;
		write_byte <= wb;
		fifo_select <= fs;
		do @(posedge clk); while (!in_ready);
		p = dma_predict(cmd, off, wb, fs);
		if (fixed && p !== res) begin
			$error("directed row result mismatch: expected %h actual %h", res, p);
			fail_count++;
		end
		expected_results.push_back(fixed ? res : p);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic wr(int c, int ix, logic [7:0] v);
		send_item(dma4_pkg::CMD_WRITE, c * 12 + ix, v, $urandom_range(0, 1));
	endtask

	// program a channel fully: source, dest, length, control
	task automatic program_channel(int c, logic [31:0] s, logic [31:0] d, logic [15:0] l,
			logic [15:0] ctl);
		int b;
		for (b = 0; b < 4; b++)
			wr(c, b, s[b*8 +: 8]);
		for (b = 0; b < 4; b++)
			wr(c, 4 + b, d[b*8 +: 8]);
		wr(c, 8, l[7:0]);
		wr(c, 9, l[15:8]);
		wr(c, 10, ctl[7:0]);
		wr(c, 11, ctl[15:8]);
	endtask

	task automatic random_item();
		int k;
		k = $urandom_range(0, 15);
		if (k < 7)
			send_item(dma4_pkg::CMD_TICK, $urandom, $urandom, $urandom);
		else if (k < 10)
			send_item(dma4_pkg::CMD_WRITE, $urandom, $urandom, $urandom);
		else
			send_item($urandom_range(1, 6), $urandom, $urandom, $urandom);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		dma_result_t got, want;
		int w;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end
			w = $urandom_range(0, 3);
			if ($urandom_range(0, 7) == 0)
				w = 0;
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = {read_byte, xfer_valid, xfer_channel, xfer_source, xfer_dest, xfer_word,
				xfer_done, irq_request, busy_res};
			if (expected_results.size() == 0) begin
				$error("result with no expectation waiting: %h", got);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.rd !== want.rd) begin
					$error("read_byte expected %h actual %h", want.rd, got.rd); fail_count++; end
				if (got.xv !== want.xv) begin
					$error("xfer_valid expected %h actual %h", want.xv, got.xv); fail_count++; end
				if (got.xch !== want.xch) begin
					$error("xfer_channel expected %h actual %h", want.xch, got.xch); fail_count++; end
				if (got.xs !== want.xs) begin
					$error("xfer_source expected %h actual %h", want.xs, got.xs); fail_count++; end
				if (got.xd !== want.xd) begin
					$error("xfer_dest expected %h actual %h", want.xd, got.xd); fail_count++; end
				if (got.xw !== want.xw) begin
					$error("xfer_word expected %h actual %h", want.xw, got.xw); fail_count++; end
				if (got.xdone !== want.xdone) begin
					$error("xfer_done expected %h actual %h", want.xdone, got.xdone); fail_count++; end
				if (got.irq !== want.irq) begin
					$error("irq_request expected %h actual %h", want.irq, got.irq); fail_count++; end
				if (got.busy !== want.busy) begin
					$error("busy_res expected %h actual %h", want.busy, got.busy); fail_count++; end
			end
		end
	end

	initial begin : stimulus
		dir_row_t rows[$];
		dma_result_t z;
		int n, c, j;
		in_valid = 1'b0;
		command = dma4_pkg::CMD_TICK;
		reg_offset = '0;
		write_byte = '0;
		fifo_select = 1'b0;
		arst_n = 1'b0;
		fail_count = 0;
		hold_off = 0;
		for (c = 0; c < 4; c++) begin
			m_src[c] = 0; m_dst[c] = 0; m_len[c] = 0; m_ctl[c] = 0;
			m_src_now[c] = 0; m_dst_now[c] = 0; m_cnt[c] = 0; m_act[c] = 0; m_cd[c] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; all-zero results are read straight off reset state
		z = '0;
		rows.push_back('{dma4_pkg::CMD_TICK, 6'd0, 8'd0, 1'b0, 1, z});
		rows.push_back('{dma4_pkg::CMD_READ, 6'd10, 8'd0, 1'b0, 1, z});
		rows.push_back('{dma4_pkg::CMD_READ, 6'd63, 8'd0, 1'b0, 1, z});    // out-of-range read
		rows.push_back('{dma4_pkg::CMD_WRITE, 6'd63, 8'hFF, 1'b1, 1, z});  // out-of-range write
		rows.push_back('{dma4_pkg::CMD_WRITE, 6'd10, 8'hFF, 1'b0, 1, z});  // low control byte
		z.rd = 8'hE0;
		rows.push_back('{dma4_pkg::CMD_READ, 6'd10, 8'd0, 1'b0, 1, z});
		z.rd = 8'h00;
		rows.push_back('{dma4_pkg::CMD_WRITE, 6'd11, 8'h7F, 1'b0, 1, z});
		z.rd = 8'h77;                                                       // bit 11 dropped
		rows.push_back('{dma4_pkg::CMD_READ, 6'd11, 8'd0, 1'b0, 1, z});
		z.rd = 8'h00;
		rows.push_back('{dma4_pkg::CMD_WRITE, 6'd47, 8'h3F, 1'b0, 1, z});
		z.rd = 8'h3F;                                                       // channel 3 keeps bit 11
		rows.push_back('{dma4_pkg::CMD_READ, 6'd47, 8'd0, 1'b0, 1, z});
		rows.push_back('{dma4_pkg::CMD_WRITE, 6'd3, 8'hFF, 1'b0, 0, z});   // source mask ch0
		rows.push_back('{dma4_pkg::CMD_WRITE, 6'd19, 8'hFF, 1'b0, 0, z});  // dest mask ch1
		rows.push_back('{dma4_pkg::CMD_WRITE, 6'd43, 8'hFF, 1'b0, 0, z});  // dest mask ch3
		rows.push_back('{dma4_pkg::CMD_HBLANK, 6'd0, 8'd0, 1'b0, 0, z});
		rows.push_back('{dma4_pkg::CMD_VBLANK, 6'd0, 8'd0, 1'b0, 0, z});
		rows.push_back('{dma4_pkg::CMD_CAP_ON, 6'd0, 8'd0, 1'b0, 0, z});
		rows.push_back('{dma4_pkg::CMD_CAP_OFF, 6'd0, 8'd0, 1'b0, 0, z});
		rows.push_back('{dma4_pkg::CMD_TIMER, 6'd0, 8'd0, 1'b1, 0, z});
		foreach (rows[i])
			send_item(rows[i].cmd, rows[i].off, rows[i].wb, rows[i].fs, rows[i].fixed,
				rows[i].res);

		// sender pauses until every result is back
		drain_results();

		// long receiver stall while items keep coming so the block backs up
		hold_off = 40;
		for (j = 0; j < 30; j++)
			send_item(dma4_pkg::CMD_TICK, 0, 0, 0);

		// random part: mostly well-formed channel setups followed by ticks
		n = 0;
		while (n < 1100) begin
			c = $urandom_range(0, 3);
			case ($urandom_range(0, 5))
			0: begin
				program_channel(c, $urandom, $urandom, $urandom_range(0, 6),
					$urandom | 16'h8000);
				n += 12;
			end
			1: begin
				program_channel(c, {$urandom_range(0, 1) ? 8'h08 : 8'h02, 24'($urandom)},
					$urandom, $urandom_range(0, 1) ? 16'h0 : 16'h0003,
					{1'b1, 1'($urandom), 2'($urandom), 12'($urandom)});
				n += 12;
			end
			2: begin
				program_channel($urandom_range(1, 2), $urandom,
					$urandom_range(0, 1) ? dma4_pkg::FIFO_A_ADDR : dma4_pkg::FIFO_B_ADDR,
					$urandom_range(1, 3),
					{2'($urandom), 2'b11, 2'($urandom), 1'b1, 9'($urandom)});
				n += 12;
			end
			3: begin
				wr(c, 11, {1'($urandom), 7'($urandom)});
				n += 1;
			end
			default: ;
			endcase
			for (j = $urandom_range(4, 30); j > 0; j--) begin
				random_item();
				n++;
			end
		end
		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: four_channel_dma_controller_unit.f
hdl/dma4_pkg.sv
hdl/dma4_front.sv
hdl/dma4_back.sv
hdl/four_channel_dma_controller_unit.sv
verif/testbench.sv
